>>> design/edge_time_velocity_estimator_assert.svh
// Assertion macros shared by the velocity estimator modules.
`ifndef EDGE_TIME_VELOCITY_ESTIMATOR_ASSERT_SVH
`define EDGE_TIME_VELOCITY_ESTIMATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ETVE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ETVE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/etve_pkg.sv
package etve_pkg;

   // Fixed field widths.
   localparam int unsigned DATA_W      = 32;
   localparam int unsigned TMO_MS_W    = 16;
   localparam int unsigned FS_FIELD_W  = 4;
   localparam int unsigned TMO_US_W    = 26;
   localparam int unsigned CSR_ADDR_W  = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   // Serial divider: 64-bit dividend, 32-bit divisor, one quotient bit per cycle.
   localparam int unsigned DIVIDEND_W  = 64;
   localparam int unsigned DIV_STEPS   = 32;
   localparam int unsigned DIV_CNT_W   = 5;

   localparam int unsigned SCALE_W     = 24;
   localparam int unsigned PROD_W      = DATA_W + SCALE_W;

   localparam int unsigned RING_DEPTH_DEFAULT = 8;
   localparam int unsigned FILTER_SIZE_RESET  = 4;
   localparam int unsigned FILTER_SIZE_MIN    = 2;

   localparam logic [TMO_MS_W-1:0] TIMEOUT_MS_RESET = 16'd50;
   localparam logic [9:0]          US_PER_MS        = 10'd1000;
   localparam logic [SCALE_W-1:0]  TICKS_SCALE      = 24'd16000000;

   localparam logic [DATA_W-1:0]   SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0]   SAT_MIN = 32'h8000_0000;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_ZERO_TIMEOUT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FILTER_SIZE  = 2'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_PUSH,
      ST_SUM_START,
      ST_SUM,
      ST_MEAN_START,
      ST_MEAN_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic sum_start;
   } ring_ctl_type;

endpackage

>>> design/etve_divider.sv
module etve_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [etve_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [etve_pkg::DATA_W-1:0]         divisor,
   output logic                                done,
   output logic                                overflow,
   output logic [etve_pkg::DATA_W-1:0]         quotient
);

   `include "edge_time_velocity_estimator_assert.svh"

   logic                                 run_ff;
   logic                                 done_ff;
   logic [etve_pkg::DIV_CNT_W-1:0]       cnt_ff;
   logic [etve_pkg::DATA_W:0]            rem_ff;
   logic [etve_pkg::DATA_W-1:0]          quo_ff;
   logic [etve_pkg::DATA_W-1:0]          den_ff;
   logic                                 ovf_ff;

   logic [etve_pkg::DATA_W:0]            shifted;
   logic                                 fits;
   logic [etve_pkg::DATA_W:0]            rem_in;

   // Restoring division: the remainder starts with the upper dividend word,
   // which must be below the divisor for the quotient to fit in 32 bits.
   always_comb begin
      shifted = {rem_ff[etve_pkg::DATA_W-1:0], quo_ff[etve_pkg::DATA_W-1]};
      fits    = (shifted >= {1'b0, den_ff});
      rem_in  = fits ? (shifted - {1'b0, den_ff}) : shifted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == etve_pkg::DIV_CNT_W'(etve_pkg::DIV_STEPS - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, dividend[etve_pkg::DIVIDEND_W-1:etve_pkg::DATA_W]};
         quo_ff <= dividend[etve_pkg::DATA_W-1:0];
         den_ff <= divisor;
         ovf_ff <= (dividend[etve_pkg::DIVIDEND_W-1:etve_pkg::DATA_W] >= divisor);
      end else if (run_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[etve_pkg::DATA_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign overflow = ovf_ff;
   assign quotient = quo_ff;

   `ETVE_ASSERT_IMPL(a_div_rem_below, clock, reset, run_ff && !ovf_ff && !start, rem_ff < {1'b0, den_ff}, "divider remainder reached the divisor")
   `ETVE_ASSERT_IMPL(a_div_done_idle, clock, reset, done_ff, !run_ff, "divider done while still running")

endmodule

>>> design/etve_ring.sv
module etve_ring #(
   parameter int unsigned RING_DEPTH = etve_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  etve_pkg::ring_ctl_type                     ctl,
   input  logic [etve_pkg::DATA_W-1:0]                sample,
   input  logic [$clog2(RING_DEPTH+1)-1:0]            filter_size,
   output logic [$clog2(RING_DEPTH+1)-1:0]            fill,
   output logic [etve_pkg::DATA_W+$clog2(RING_DEPTH):0] sum,
   output logic                                       sum_done
);

   `include "edge_time_velocity_estimator_assert.svh"

   localparam int unsigned POS_W  = $clog2(RING_DEPTH);
   localparam int unsigned FILL_W = $clog2(RING_DEPTH + 1);
   localparam int unsigned SUM_W  = etve_pkg::DATA_W + $clog2(RING_DEPTH) + 1;

   logic [etve_pkg::DATA_W-1:0] entries_ff [RING_DEPTH];
   logic [POS_W-1:0]            pos_ff;
   logic [FILL_W-1:0]           fill_ff;
   logic [POS_W-1:0]            idx_ff;
   logic [SUM_W-1:0]            acc_ff;
   logic                        busy_ff;
   logic                        done_ff;

   logic [FILL_W-1:0]           pos_next;
   logic [FILL_W-1:0]           idx_next;
   logic [etve_pkg::DATA_W-1:0] cur;

   always_comb begin
      pos_next = FILL_W'(pos_ff) + FILL_W'(1);
      idx_next = FILL_W'(idx_ff) + FILL_W'(1);
      cur      = entries_ff[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         fill_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.clear) begin
            pos_ff  <= '0;
            fill_ff <= '0;
         end else if (ctl.push) begin
            pos_ff <= (pos_next >= filter_size) ? '0 : pos_next[POS_W-1:0];
            if (fill_ff < filter_size) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
         if (ctl.sum_start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (idx_next == fill_ff)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Entries are always written before they are summed, so they need no reset.
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         entries_ff[pos_ff] <= sample;
      end
      if (ctl.sum_start) begin
         idx_ff <= '0;
         acc_ff <= '0;
      end else if (busy_ff) begin
         idx_ff <= idx_next[POS_W-1:0];
         acc_ff <= acc_ff + {{(SUM_W-etve_pkg::DATA_W){cur[etve_pkg::DATA_W-1]}}, cur};
      end
   end

   assign fill     = fill_ff;
   assign sum      = acc_ff;
   assign sum_done = done_ff;

   `ETVE_ASSERT_IMPL(a_ring_fill_bound, clock, reset, 1'b1, fill_ff <= filter_size, "ring fill exceeds filter size")
   `ETVE_ASSERT_IMPL(a_ring_idx_bound, clock, reset, busy_ff, FILL_W'(idx_ff) < fill_ff, "ring sum index past fill")

endmodule

>>> design/edge_time_velocity_estimator.sv
// Edge-time velocity estimator.
// Input channel req_*: one beat per update carrying the current time, the time
// of the latest encoder edge and the encoder count. Result channel rsp_*: one
// beat per update with the filtered velocity (1/16 tick per second) and the
// stopped flag. Both channels move a beat when valid is high and stall is low.
// Configuration channel csr_*: index 0 sets the timeout in ms, index 1 sets the
// filter size and empties the averaging ring; writes are taken while idle.
// An update that computes a new sample passes from acceptance to the result
// register through two runs of the shared bit-serial divider, for the sample
// and for the mean, and the ring accumulator, which adds one stored sample
// per cycle, so its time grows with the number of samples held in the ring.
// Timeout, baseline capture and held-estimate updates go from the check
// state straight to the final state. One update is in work at a time; the
// next beat can be accepted in the cycle after the result register loads,
// so a new update can start while the previous result still waits there.
// A stalled receiver keeps that result stable; a second result then waits
// in the final state until the output register frees up.
// Synchronous reset restores the default timeout and filter size, drops the
// baseline, zeroes the held velocity and empties the ring.
module edge_time_velocity_estimator #(
   parameter int unsigned RING_DEPTH = etve_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [31:0]                           req_now_us,
   input  logic [31:0]                           req_edge_time_us,
   input  logic signed [31:0]                    req_encoder_count,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [31:0]                    rsp_velocity,
   output logic                                  rsp_stopped,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [etve_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [etve_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   `include "edge_time_velocity_estimator_assert.svh"

   localparam int unsigned FILL_W   = $clog2(RING_DEPTH + 1);
   localparam int unsigned SUM_W    = etve_pkg::DATA_W + $clog2(RING_DEPTH) + 1;
   localparam int unsigned FS_RESET = (etve_pkg::FILTER_SIZE_RESET > RING_DEPTH) ?
                                      RING_DEPTH : etve_pkg::FILTER_SIZE_RESET;
   localparam int unsigned DW       = etve_pkg::DATA_W;

   etve_pkg::state_type state_ff, state_in;

   // Configuration and persistent state.
   logic [etve_pkg::TMO_US_W-1:0] tmo_us_ff;
   logic [FILL_W-1:0]             filter_size_ff;
   logic [DW-1:0]                 base_count_ff;
   logic [DW-1:0]                 base_edge_ff;
   logic                          have_base_ff;
   logic [DW-1:0]                 held_ff;
   logic                          rsp_valid_ff;

   // Per-update working registers.
   logic [DW-1:0]                 now_ff;
   logic [DW-1:0]                 edge_ff;
   logic [DW-1:0]                 count_ff;
   logic                          stopped_ff;
   logic                          neg_ff;
   logic [DW-1:0]                 mag_dc_ff;
   logic [DW-1:0]                 dt_ff;
   logic [etve_pkg::PROD_W-1:0]   prod_ff;
   logic [DW-1:0]                 sample_ff;
   logic                          mean_neg_ff;
   logic [DW-1:0]                 rsp_velocity_ff;
   logic                          rsp_stopped_ff;

   logic                          csr_write;
   logic                          timeout;
   logic                          estimate;
   logic [DW-1:0]                 dc;
   logic [DW-1:0]                 dt;
   logic [DW-1:0]                 elapsed;
   logic                          out_free;
   logic [etve_pkg::FS_FIELD_W-1:0] fs_field;
   logic [FILL_W-1:0]             fs_clamped;

   logic                          div_start;
   logic [etve_pkg::DIVIDEND_W-1:0] div_dividend;
   logic [DW-1:0]                 div_divisor;
   logic                          div_done;
   logic                          div_overflow;
   logic [DW-1:0]                 div_quotient;
   logic [DW-1:0]                 sample_in;

   etve_pkg::ring_ctl_type        ring_ctl;
   logic [FILL_W-1:0]             ring_fill;
   logic [SUM_W-1:0]              ring_sum;
   logic                          ring_sum_done;
   logic [SUM_W-1:0]              sum_mag;

   always_comb begin
      elapsed  = now_ff - edge_ff;
      timeout  = (edge_ff != '0) && (elapsed > {{(DW-etve_pkg::TMO_US_W){1'b0}}, tmo_us_ff});
      dc       = count_ff - base_count_ff;
      dt       = edge_ff - base_edge_ff;
      estimate = !timeout && have_base_ff && (dc != '0) && (dt != '0);
      out_free = !rsp_valid_ff || !rsp_stall;
      csr_write = csr_valid && csr_ready;
      fs_field = csr_wdata[etve_pkg::FS_FIELD_W-1:0];
      if (fs_field < etve_pkg::FS_FIELD_W'(etve_pkg::FILTER_SIZE_MIN)) begin
         fs_clamped = FILL_W'(etve_pkg::FILTER_SIZE_MIN);
      end else if (32'(fs_field) > RING_DEPTH) begin
         fs_clamped = FILL_W'(RING_DEPTH);
      end else begin
         fs_clamped = FILL_W'(fs_field);
      end
      sum_mag = ring_sum[SUM_W-1] ? (~ring_sum + 1'b1) : ring_sum;
   end

   // Saturate the signed sample from the quotient magnitude.
   always_comb begin
      if (!neg_ff) begin
         sample_in = (div_overflow || div_quotient[DW-1]) ? etve_pkg::SAT_MAX : div_quotient;
      end else if (div_overflow || (div_quotient > etve_pkg::SAT_MIN)) begin
         sample_in = etve_pkg::SAT_MIN;
      end else begin
         sample_in = ~div_quotient + 1'b1;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         etve_pkg::ST_IDLE:       if (req_valid) state_in = etve_pkg::ST_CHECK;
         etve_pkg::ST_CHECK:      state_in = estimate ? etve_pkg::ST_MUL : etve_pkg::ST_DONE;
         etve_pkg::ST_MUL:        state_in = etve_pkg::ST_DIV_START;
         etve_pkg::ST_DIV_START:  state_in = etve_pkg::ST_DIV_WAIT;
         etve_pkg::ST_DIV_WAIT:   if (div_done) state_in = etve_pkg::ST_PUSH;
         etve_pkg::ST_PUSH:       state_in = etve_pkg::ST_SUM_START;
         etve_pkg::ST_SUM_START:  state_in = etve_pkg::ST_SUM;
         etve_pkg::ST_SUM:        if (ring_sum_done) state_in = etve_pkg::ST_MEAN_START;
         etve_pkg::ST_MEAN_START: state_in = etve_pkg::ST_MEAN_WAIT;
         etve_pkg::ST_MEAN_WAIT:  if (div_done) state_in = etve_pkg::ST_DONE;
         etve_pkg::ST_DONE:       if (out_free) state_in = etve_pkg::ST_IDLE;
         default:                 state_in = etve_pkg::ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_stall          = 1'b1;
      csr_ready          = 1'b0;
      div_start          = 1'b0;
      ring_ctl           = '0;
      div_dividend       = {{(etve_pkg::DIVIDEND_W-etve_pkg::PROD_W){1'b0}}, prod_ff};
      div_divisor        = dt_ff;
      unique case (state_ff)
         etve_pkg::ST_IDLE: begin
            // Nothing is taken while reset is held.
            req_stall = reset;
            csr_ready = !reset;
            ring_ctl.clear = csr_valid && (csr_addr == etve_pkg::CSR_FILTER_SIZE);
         end
         etve_pkg::ST_CHECK:      ring_ctl.clear = timeout;
         etve_pkg::ST_DIV_START:  div_start = 1'b1;
         etve_pkg::ST_PUSH:       ring_ctl.push = 1'b1;
         etve_pkg::ST_SUM_START:  ring_ctl.sum_start = 1'b1;
         etve_pkg::ST_MEAN_START: begin
            div_start    = 1'b1;
            div_dividend = {{(etve_pkg::DIVIDEND_W-SUM_W){1'b0}}, sum_mag};
            div_divisor  = {{(DW-FILL_W){1'b0}}, ring_fill};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= etve_pkg::ST_IDLE;
         tmo_us_ff      <= etve_pkg::TMO_US_W'(etve_pkg::TIMEOUT_MS_RESET * etve_pkg::US_PER_MS);
         filter_size_ff <= FILL_W'(FS_RESET);
         base_count_ff  <= '0;
         base_edge_ff   <= '0;
         have_base_ff   <= 1'b0;
         held_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write && (csr_addr == etve_pkg::CSR_ZERO_TIMEOUT)) begin
            tmo_us_ff <= etve_pkg::TMO_US_W'(csr_wdata) *
                         etve_pkg::TMO_US_W'(etve_pkg::US_PER_MS);
         end
         if (csr_write && (csr_addr == etve_pkg::CSR_FILTER_SIZE)) begin
            filter_size_ff <= fs_clamped;
         end
         if (state_ff == etve_pkg::ST_CHECK) begin
            if (timeout) begin
               held_ff       <= '0;
               have_base_ff  <= 1'b0;
               base_count_ff <= count_ff;
               base_edge_ff  <= edge_ff;
            end else if (!have_base_ff) begin
               have_base_ff  <= (edge_ff != '0);
               base_count_ff <= count_ff;
               base_edge_ff  <= edge_ff;
            end else if (estimate) begin
               base_count_ff <= count_ff;
               base_edge_ff  <= edge_ff;
            end
         end
         if ((state_ff == etve_pkg::ST_MEAN_WAIT) && div_done) begin
            held_ff <= mean_neg_ff ? (~div_quotient + 1'b1) : div_quotient;
         end
         if ((state_ff == etve_pkg::ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == etve_pkg::ST_IDLE) && req_valid) begin
         now_ff   <= req_now_us;
         edge_ff  <= req_edge_time_us;
         count_ff <= req_encoder_count;
      end
      if (state_ff == etve_pkg::ST_CHECK) begin
         stopped_ff <= timeout;
         neg_ff     <= dc[DW-1];
         mag_dc_ff  <= dc[DW-1] ? (~dc + 1'b1) : dc;
         dt_ff      <= dt;
      end
      if (state_ff == etve_pkg::ST_MUL) begin
         prod_ff <= {{etve_pkg::SCALE_W{1'b0}}, mag_dc_ff} *
                    {{DW{1'b0}}, etve_pkg::TICKS_SCALE};
      end
      if ((state_ff == etve_pkg::ST_DIV_WAIT) && div_done) begin
         sample_ff <= sample_in;
      end
      if (state_ff == etve_pkg::ST_MEAN_START) begin
         mean_neg_ff <= ring_sum[SUM_W-1];
      end
      if ((state_ff == etve_pkg::ST_DONE) && out_free) begin
         rsp_velocity_ff <= held_ff;
         rsp_stopped_ff  <= stopped_ff;
      end
   end

   etve_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .overflow (div_overflow),
      .quotient (div_quotient)
   );

   etve_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ring_ctl),
      .sample      (sample_ff),
      .filter_size (filter_size_ff),
      .fill        (ring_fill),
      .sum         (ring_sum),
      .sum_done    (ring_sum_done)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_velocity = rsp_velocity_ff;
   assign rsp_stopped  = rsp_stopped_ff;

   `ETVE_ASSERT_IMPL(a_stop_zero, clock, reset,
      rsp_valid_ff && rsp_stopped_ff, rsp_velocity_ff == '0,
      "stopped result with nonzero velocity")
   `ETVE_ASSERT_IMPL(a_div_done_state, clock, reset, div_done,
      (state_ff == etve_pkg::ST_DIV_WAIT) || (state_ff == etve_pkg::ST_MEAN_WAIT),
      "divider finished outside a wait state")
   `ETVE_ASSERT_NEXT(a_push_fill, clock, reset, ring_ctl.push, ring_fill != '0,
      "ring empty after a push")

endmodule
